// ===== src/mcf_pkg.sv =====
// shared types, constants and crc function for the command packet framer
package mcf_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned IdW   = 7;
  localparam int unsigned CrcW  = 7;
  localparam int unsigned PosW  = 3;

  localparam logic [ByteW-1:0] CrcPoly = 8'h91;
  localparam logic [ByteW-1:0] CfgKeyA = 8'h55;
  localparam logic [ByteW-1:0] CfgKeyB = 8'h2A;

  localparam logic [IdW-1:0]   DeviceIdRst  = 7'd9;
  localparam logic [ByteW-1:0] StartByteRst = 8'hAA;

  // byte positions inside a packet
  localparam logic [PosW-1:0] PosStart  = 3'd0;
  localparam logic [PosW-1:0] PosDevice = 3'd1;
  localparam logic [PosW-1:0] PosCmd    = 3'd2;
  localparam logic [PosW-1:0] PosParam  = 3'd3;
  localparam logic [PosW-1:0] PosValue  = 3'd4;
  localparam logic [PosW-1:0] PosKeyA   = 3'd5;
  localparam logic [PosW-1:0] PosKeyB   = 3'd6;
  localparam logic [PosW-1:0] PosCrcCfg = 3'd7;

  typedef enum logic [1:0] {
    FUNC_CMD       = 2'd0,
    FUNC_CMD_PARAM = 2'd1,
    FUNC_SET_CFG   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_DEVICE_ID    = 2'd0,
    REG_START_BYTE   = 2'd1,
    REG_LINK_ENABLED = 2'd2
  } reg_idx_e;

  typedef struct packed {
    func_e            func;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] param;
    logic [ByteW-1:0] value;
  } pkt_req_t;

  typedef struct packed {
    logic [IdW-1:0]   device_id;
    logic [ByteW-1:0] start_byte;
  } frame_cfg_t;

  // one byte through the reflected crc-7, lsb first
  function automatic logic [CrcW-1:0] crc7_update(input logic [CrcW-1:0]  crc,
                                                  input logic [ByteW-1:0] data);
    logic [ByteW-1:0] c;
    c = {1'b0, crc} ^ data;
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c ^ CrcPoly) >> 1) : (c >> 1);
    end
    return c[CrcW-1:0];
  endfunction

endpackage

// ===== src/motor_command_packet_crc7_framer_top.sv =====
// top level of the crc-7 command packet framer for a dual-motor controller
//
//  channel   | direction | signals                              | contents
//  ----------+-----------+--------------------------------------+--------------------------
//  s_axis    | in        | tvalid tready tdata[23:0] tuser[1:0] | one packet request
//  m_axis    | out       | tvalid tready tdata[7:0] tlast       | one packet byte per transfer
//  cfg       | in        | valid ready index[1:0] data[7:0]     | register write
//
// a request of kind 0, 1 or 2 gives 4, 5 or 8 byte transfers, one per cycle while
// m_axis is ready; the single byte serialiser in the back end starts the next
// packet only once the last byte of the current one is in the output register
// a request is taken whenever the request queue has room, also while bytes
// of earlier packets are still waiting on m_axis
// reset (async, active low) empties the queue and the output register and
// restores device id 9, start byte 0xaa and link disabled
// with the link disabled, or for kind 3, the request is taken and dropped
module motor_command_packet_crc7_framer_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // command[7:0], param[15:8], value[23:16]
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  // byte channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // tx_byte[7:0]
  output logic        m_axis_tlast,
  // register write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,   // 0 device id, 1 start byte, 2 link enable
  input  logic [7:0]  cfg_data_i
);
  import mcf_pkg::*;

  pkt_req_t   req;
  pkt_req_t   q_push_data;
  pkt_req_t   q_head;
  frame_cfg_t frame_cfg;
  logic       q_push, q_full, q_pop, q_empty;

  // unpack the request transfer
  assign req.func    = func_e'(s_axis_tuser);
  assign req.command = s_axis_tdata[7:0];
  assign req.param   = s_axis_tdata[15:8];
  assign req.value   = s_axis_tdata[23:16];

  // front: registers and filtering of requests
  mcf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_push_data),
    .frame_cfg_o (frame_cfg)
  );

  // decouples request intake from byte output
  mcf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // back: serialises the head request, crc built as bytes go out
  mcf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_cfg_i (frame_cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== src/mcf_queue.sv =====
// short request queue between front and back
module mcf_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mcf_pkg::pkt_req_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output mcf_pkg::pkt_req_t head_o
);
  import mcf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  pkt_req_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/mcf_front.sv =====
// front end: config registers, request accept and packet kind filter
module mcf_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [mcf_pkg::ByteW-1:0] cfg_data_i,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  mcf_pkg::pkt_req_t        req_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output mcf_pkg::pkt_req_t        q_data_o,
  output mcf_pkg::frame_cfg_t      frame_cfg_o
);
  import mcf_pkg::*;

  logic [IdW-1:0]   device_id_q, device_id_d;
  logic [ByteW-1:0] start_byte_q, start_byte_d;
  logic             link_en_q, link_en_d;
  logic             kind_ok;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    device_id_d  = device_id_q;
    start_byte_d = start_byte_q;
    link_en_d    = link_en_q;
    if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_DEVICE_ID:    device_id_d  = cfg_data_i[IdW-1:0];
        REG_START_BYTE:   start_byte_d = cfg_data_i;
        REG_LINK_ENABLED: link_en_d    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q  <= DeviceIdRst;
      start_byte_q <= StartByteRst;
      link_en_q    <= 1'b0;
    end else begin
      device_id_q  <= device_id_d;
      start_byte_q <= start_byte_d;
      link_en_q    <= link_en_d;
    end
  end

  // unused kind and disabled link are swallowed here
  always_comb begin
    case (req_i.func)
      FUNC_CMD, FUNC_CMD_PARAM, FUNC_SET_CFG: kind_ok = 1'b1;
      default:                                kind_ok = 1'b0;
    endcase
  end

  assign req_ready_o = !q_full_i;
  assign q_push_o    = req_valid_i && !q_full_i && link_en_q && kind_ok;
  assign q_data_o    = req_i;

  assign frame_cfg_o.device_id  = device_id_q;
  assign frame_cfg_o.start_byte = start_byte_q;

endmodule

// ===== src/mcf_back.sv =====
// back end: byte serialiser with running crc and output register
module mcf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mcf_pkg::frame_cfg_t       frame_cfg_i,
  input  logic                      q_empty_i,
  input  mcf_pkg::pkt_req_t         q_head_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mcf_pkg::ByteW-1:0] out_byte_o,
  output logic                      out_last_o
);
  import mcf_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             last_q, last_d;
  logic [ByteW-1:0] cur_byte;
  logic [PosW-1:0]  last_pos;
  logic             is_last, advance;
  logic [ByteW-1:0] crc_byte;

  assign crc_byte = {1'b0, crc_q};

  always_comb begin
    case (q_head_i.func)
      FUNC_CMD:       last_pos = PosParam;
      FUNC_CMD_PARAM: last_pos = PosValue;
      default:        last_pos = PosCrcCfg;
    endcase
  end

  always_comb begin
    case (pos_q)
      PosStart:  cur_byte = frame_cfg_i.start_byte;
      PosDevice: cur_byte = {1'b0, frame_cfg_i.device_id};
      PosCmd:    cur_byte = q_head_i.command;
      PosParam:  cur_byte = (q_head_i.func == FUNC_CMD) ? crc_byte : q_head_i.param;
      PosValue:  cur_byte = (q_head_i.func == FUNC_CMD_PARAM) ? crc_byte : q_head_i.value;
      PosKeyA:   cur_byte = CfgKeyA;
      PosKeyB:   cur_byte = CfgKeyB;
      default:   cur_byte = crc_byte;
    endcase
  end

  assign is_last = (pos_q == last_pos);
  assign advance = !q_empty_i && (!valid_q || out_ready_i);
  assign q_pop_o = advance && is_last;

  always_comb begin
    pos_d   = pos_q;
    crc_d   = crc_q;
    byte_d  = byte_q;
    last_d  = last_q;
    valid_d = valid_q && !out_ready_i;
    if (advance) begin
      valid_d = 1'b1;
      byte_d  = cur_byte;
      last_d  = is_last;
      pos_d   = is_last ? '0 : pos_q + 1'b1;
      crc_d   = is_last ? '0 : crc7_update(crc_q, cur_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      crc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

// ===== tb/sv/motor_command_packet_crc7_framer_top_tb.sv =====
// self-checking testbench for the crc-7 command packet framer top level
module motor_command_packet_crc7_framer_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mcf_pkg::*;

  // ---------------------------------------------------------------------------
  // constants
  // ---------------------------------------------------------------------------

  // packet kind with no meaning, taken and dropped by the block
  localparam logic [1:0] FuncUnused = 2'd3;
  // register index outside the map, the write must leave every register alone
  localparam logic [1:0] RegUnused  = 2'd3;

  // polynomial folded into the shift: (c ^ poly) >> 1 == (c >> 1) ^ (poly >> 1)
  localparam logic [ByteW-1:0] CrcPolyFolded = CrcPoly >> 1;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned RstCycles   = 5;
  localparam int unsigned SettleCycles = 32;   // queue plus serialiser, dropped requests too
  localparam int unsigned IdleLimit   = 2000;  // cycles with no transfer on any channel
  localparam int unsigned RandPhases  = 6;
  localparam int unsigned PhaseItems  = 50;

  // ---------------------------------------------------------------------------
  // types
  // ---------------------------------------------------------------------------

  // one packet request as it travels on s_axis
  typedef struct packed {
    logic [1:0]       func;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] param;
    logic [ByteW-1:0] value;
  } cmd_req_t;

  // one expected byte transfer on m_axis
  typedef struct packed {
    logic [ByteW-1:0] tx_byte;
    logic             last;
  } pkt_byte_t;

  // ---------------------------------------------------------------------------
  // dut signals
  // ---------------------------------------------------------------------------

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // command[7:0], param[15:8], value[23:16]
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // tx_byte[7:0]
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;

  motor_command_packet_crc7_framer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // testbench state
  // ---------------------------------------------------------------------------

  cmd_req_t  req_q[$];         // requests waiting to be driven
  pkt_byte_t pkt_bytes_q[$];   // bytes the framer still owes us, oldest first

  // shadow copy of the framer registers, updated on each register transfer
  logic [IdW-1:0]   dev_id_sh;
  logic [ByteW-1:0] start_sh;
  logic             link_on_sh;

  bit          req_live;        // s_axis_tvalid is up and the transfer is still open
  int unsigned burst_left;
  int unsigned gap_left;
  bit          drain_hold;      // sender paused until every expected byte is out
  int unsigned drain_after;
  int unsigned sent_since_drain;

  logic [15:0] stall_pat;
  logic [5:0]  stall_pos;

  int unsigned idle_cycles;
  int unsigned mismatches;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one byte through the reflected crc-7, lsb first, seeded by the caller
  function automatic logic [ByteW-1:0] crc7_step(input logic [ByteW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = crc ^ b;
    repeat (ByteW) r = r[0] ? ((r >> 1) ^ CrcPolyFolded) : (r >> 1);
    return r;
  endfunction

  // build the packet a request asks for and queue its bytes, none with the link off or for the unused kind
  function automatic void frame_request(input cmd_req_t req);
    logic [ByteW-1:0] pkt [8];
    int               len;
    logic [ByteW-1:0] crc;
    if (!link_on_sh || req.func == FuncUnused) return;
    pkt[PosStart]  = start_sh;
    pkt[PosDevice] = {1'b0, dev_id_sh};
    pkt[PosCmd]    = req.command;
    len = 3;
    if (req.func != FUNC_CMD) begin
      pkt[PosParam] = req.param;
      len = 4;
    end
    if (req.func == FUNC_SET_CFG) begin
      pkt[PosValue] = req.value;
      pkt[PosKeyA]  = CfgKeyA;
      pkt[PosKeyB]  = CfgKeyB;
      len = 7;
    end
    crc = '0;
    for (int k = 0; k < len; k++) crc = crc7_step(crc, pkt[k]);
    pkt[len] = crc;
    len++;
    for (int k = 0; k < len; k++) pkt_bytes_q.push_back('{tx_byte: pkt[k], last: (k == len - 1)});
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_req(input logic [1:0] f, input logic [ByteW-1:0] c,
                                   input logic [ByteW-1:0] p, input logic [ByteW-1:0] v);
    req_q.push_back('{func: f, command: c, param: p, value: v});
  endfunction

  // mostly well-formed kinds, with the odd unused kind thrown in
  function automatic void push_rand_req();
    logic [1:0] f;
    if ($urandom_range(0, 99) < 8) f = FuncUnused;
    else f = 2'($urandom_range(0, 2));
    push_req(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
  endfunction

  // one register transfer; valid drops between writes
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_DEVICE_ID:    dev_id_sh  = data[IdW-1:0];
      REG_START_BYTE:   start_sh   = data;
      REG_LINK_ENABLED: link_on_sh = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // nothing left to drive, nothing owed, then let dropped requests flush through
  task automatic wait_idle();
    while (req_q.size() != 0 || req_live || pkt_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps, drain pauses
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (drain_hold && pkt_bytes_q.size() == 0) begin
      drain_hold       = 1'b0;
      sent_since_drain = 0;
      drain_after      = $urandom_range(30, 90);
    end
    if (!req_live) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() == 0 || drain_hold) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req_q[0].value, req_q[0].param, req_q[0].command};
        s_axis_tuser  <= req_q[0].func;
        req_live = 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          // about a third of the bursts run straight into the next one
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // request transfer: predict the packet it asks for
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      frame_request(req_q.pop_front());
      req_live = 1'b0;
      sent_since_drain++;
      if (sent_since_drain >= drain_after) drain_hold = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // byte receiver: ready rotates a 16-bit pattern, redrawn when stall_pos wraps, stalls vary over cycles
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (stall_pos == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pat = '1;
        1:       stall_pat = 16'($urandom_range(0, 65535)) | 16'h0001;
        2:       stall_pat = 16'($urandom_range(0, 65535)) | 16'($urandom_range(0, 65535));
        default: stall_pat = (16'($urandom_range(0, 65535)) & 16'($urandom_range(0, 65535)))
                             | 16'h0001;
      endcase
    end
    m_axis_tready <= stall_pat[stall_pos[3:0]];
    stall_pos++;
  end

  // byte transfer: compare with the oldest byte owed
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pkt_bytes_q.size() == 0) begin
        $error("byte transfer with nothing owed: tx_byte %02h last %0b",
               m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        if (m_axis_tdata !== pkt_bytes_q[0].tx_byte) begin
          $error("tx_byte: expected %02h, actual %02h", pkt_bytes_q[0].tx_byte, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tlast !== pkt_bytes_q[0].last) begin
          $error("last: expected %0b, actual %0b", pkt_bytes_q[0].last, m_axis_tlast);
          mismatches++;
        end
        void'(pkt_bytes_q.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: any transfer on any channel counts as progress
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("motor_command_packet_crc7_framer_top: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    dev_id_sh     = DeviceIdRst;
    start_sh      = StartByteRst;
    link_on_sh    = 1'b0;
    req_live      = 1'b0;
    burst_left    = 1;
    gap_left      = 0;
    drain_hold    = 1'b0;
    drain_after   = 40;
    sent_since_drain = 0;
    stall_pat     = '1;
    stall_pos     = '0;
    idle_cycles   = 0;
    mismatches    = 0;

    repeat (RstCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // link is off out of reset: every kind must be swallowed
    push_req(FUNC_CMD,       8'h01, 8'h02, 8'h03);
    push_req(FUNC_CMD_PARAM, 8'hff, 8'hff, 8'hff);
    push_req(FUNC_SET_CFG,   8'h80, 8'h40, 8'h20);
    push_req(FuncUnused,     8'h7f, 8'h00, 8'hff);
    wait_idle();

    // reset device id and start byte, link switched on
    write_reg(REG_LINK_ENABLED, 8'h01);
    push_req(FUNC_CMD,       8'h00, 8'h00, 8'h00);
    push_req(FUNC_CMD,       8'hff, 8'hff, 8'hff);   // param and value unused here
    push_req(FUNC_CMD_PARAM, 8'h00, 8'hff, 8'ha5);   // value unused here
    push_req(FUNC_CMD_PARAM, 8'hff, 8'h00, 8'h00);
    push_req(FUNC_SET_CFG,   8'h00, 8'h00, 8'h00);
    push_req(FUNC_SET_CFG,   8'hff, 8'hff, 8'hff);
    push_req(FuncUnused,     8'h12, 8'h34, 8'h56);
    wait_idle();

    // all-zero packet keeps the crc at zero
    write_reg(REG_DEVICE_ID,  8'h00);
    write_reg(REG_START_BYTE, 8'h00);
    push_req(FUNC_CMD, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // start byte 0x01 takes the crc through its single-step value 0x41
    write_reg(REG_START_BYTE, 8'h01);
    push_req(FUNC_CMD, 8'h00, 8'h5a, 8'ha5);
    push_req(FUNC_SET_CFG, 8'h01, 8'h80, 8'h7f);
    wait_idle();

    // top bit of a device id write is dropped, unmapped index changes nothing
    write_reg(REG_DEVICE_ID,  8'hff);
    write_reg(REG_START_BYTE, 8'hff);
    write_reg(RegUnused,      8'h5a);
    push_req(FUNC_CMD,       8'h80, 8'h01, 8'h01);
    push_req(FUNC_CMD_PARAM, 8'h01, 8'h80, 8'h01);
    push_req(FUNC_SET_CFG,   8'haa, 8'h55, 8'hcc);
    wait_idle();

    // link off again mid-run
    write_reg(REG_LINK_ENABLED, 8'h00);
    push_req(FUNC_CMD,     8'h33, 8'h44, 8'h55);
    push_req(FUNC_SET_CFG, 8'h66, 8'h77, 8'h88);
    wait_idle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DEVICE_ID,  8'h7f);
          write_reg(REG_START_BYTE, 8'hff);
        end
        1: begin
          write_reg(REG_DEVICE_ID,  8'h00);
          write_reg(REG_START_BYTE, 8'h00);
        end
        default: begin
          write_reg(REG_DEVICE_ID,  8'($urandom_range(0, 255)));
          write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
        end
      endcase
      write_reg(REG_LINK_ENABLED, 8'($urandom_range(0, 255)) | 8'h01);
      for (int n = 0; n < PhaseItems; n++) push_rand_req();
      wait_idle();

      // a short stretch with the link off, random upper bits in the write
      if (ph == 2) begin
        write_reg(REG_LINK_ENABLED, 8'($urandom_range(0, 255)) & 8'hfe);
        for (int n = 0; n < 12; n++) push_rand_req();
        wait_idle();
      end
    end

    if (mismatches == 0) begin
      $display("motor_command_packet_crc7_framer_top: match");
    end else begin
      $display("motor_command_packet_crc7_framer_top: mismatch");
    end
    $finish;
  end

endmodule
